>>> rtl/aidr_pkg.sv
`timescale 1ns / 1ps

package aidr_pkg;

    localparam int IN_CHANNELS  = 8;
    localparam int OUT_CHANNELS = 8;
    localparam int COUNT_BITS   = 8;

    localparam int CHAN_W    = (IN_CHANNELS > 1) ? $clog2(IN_CHANNELS) : 1;
    localparam int OUT_IDX_W = (OUT_CHANNELS > 1) ? $clog2(OUT_CHANNELS) : 1;
    localparam int STABLE_W  = 8;
    localparam int TARGET_W  = 4;
    localparam int CMP_W     = (COUNT_BITS > STABLE_W) ? COUNT_BITS : STABLE_W;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [3:0]            NO_OUTPUT = 4'd8;

    // configuration register indexes
    localparam logic [2:0] REG_ENABLE     = 3'd0;
    localparam logic [2:0] REG_IN_NORMAL  = 3'd1;
    localparam logic [2:0] REG_STABLE     = 3'd2;
    localparam logic [2:0] REG_TARGET_MAP = 3'd3;
    localparam logic [2:0] REG_OUT_NORMAL = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } aidr_state_t;

    typedef struct packed {
        logic              load;   // capture sample word
        logic              prime;  // first tick: load accepted levels
        logic              step;   // process channel chan
        logic              flush;  // push pending result as last of tick
        logic [CHAN_W-1:0] chan;
    } aidr_cmd_t;

    typedef struct packed {
        logic primed;
        logic hit;        // current channel yields a result
        logic pend_valid;
        logic out_free;   // output register can take a word this cycle
    } aidr_sts_t;

    typedef struct packed {
        logic [2:0] in_channel;
        logic       new_level;
        logic       abnormal;
        logic [3:0] out_channel;
        logic       out_drive;
    } aidr_res_t;

endpackage

>>> rtl/aidr_ctrl.sv
`timescale 1ns / 1ps

module aidr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  aidr_pkg::aidr_sts_t sts,
    output aidr_pkg::aidr_cmd_t cmd
);

    aidr_pkg::aidr_state_t state_reg, state_next;
    logic [aidr_pkg::CHAN_W-1:0] chan_reg, chan_next;

    logic in_acc;
    logic stall;
    logic last_chan;

    assign in_acc    = in_valid && in_ready;
    assign stall     = sts.hit && sts.pend_valid && !sts.out_free;
    assign last_chan = (chan_reg == aidr_pkg::CHAN_W'(aidr_pkg::IN_CHANNELS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= aidr_pkg::ST_IDLE;
            chan_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            chan_reg  <= chan_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        chan_next  = chan_reg;
        case (state_reg)
            aidr_pkg::ST_IDLE:
            begin
                chan_next = '0;
                if (in_acc && sts.primed)
                    state_next = aidr_pkg::ST_SCAN;
            end
            aidr_pkg::ST_SCAN:
            begin
                if (!stall)
                begin
                    if (last_chan)
                        state_next = aidr_pkg::ST_FLUSH;
                    else
                        chan_next = chan_reg + 1'b1;
                end
            end
            aidr_pkg::ST_FLUSH:
            begin
                if (!sts.pend_valid || sts.out_free)
                    state_next = aidr_pkg::ST_IDLE;
            end
            default:
                state_next = aidr_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready  = 1'b0;
        cmd       = '0;
        cmd.chan  = chan_reg;
        case (state_reg)
            aidr_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.load  = in_valid;
                cmd.prime = in_valid && !sts.primed;
            end
            aidr_pkg::ST_SCAN:
                cmd.step = !stall;
            aidr_pkg::ST_FLUSH:
                cmd.flush = sts.pend_valid && sts.out_free;
            default:
                cmd = '0;
        endcase
    end

endmodule

>>> rtl/aidr_dp.sv
`timescale 1ns / 1ps

module aidr_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_data,
    input  logic [7:0]          alarm_sample,
    input  aidr_pkg::aidr_cmd_t cmd,
    output aidr_pkg::aidr_sts_t sts,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [2:0]          in_channel,
    output logic                new_level,
    output logic                abnormal,
    output logic [3:0]          out_channel,
    output logic                out_drive,
    output logic                last_event
);

    localparam int NI = aidr_pkg::IN_CHANNELS;
    localparam int CB = aidr_pkg::COUNT_BITS;

    logic [7:0]  enable_reg;
    logic [7:0]  in_normal_reg;
    logic [63:0] stable_reg;
    logic [31:0] target_map_reg;
    logic [7:0]  out_normal_reg;

    logic [NI-1:0] sample_reg;
    logic [NI-1:0] levels_reg, levels_next;
    logic [CB-1:0] count_reg [NI];
    logic          primed_reg;

    aidr_pkg::aidr_res_t pend_reg, res_now, out_reg;
    logic                pend_valid_reg;
    logic                out_valid_reg;
    logic                out_last_reg;

    logic                              lvl, old, differ, reach, en;
    logic [CB-1:0]                     cnt, cnt_inc, cnt_next;
    logic [aidr_pkg::STABLE_W-1:0]     stable;
    logic [aidr_pkg::TARGET_W-1:0]     tgt;
    logic                              push_mid;

    // config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= '0;
            in_normal_reg  <= '0;
            stable_reg     <= '0;
            target_map_reg <= '1;
            out_normal_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                aidr_pkg::REG_ENABLE:     enable_reg     <= cfg_data[7:0];
                aidr_pkg::REG_IN_NORMAL:  in_normal_reg  <= cfg_data[7:0];
                aidr_pkg::REG_STABLE:     stable_reg     <= cfg_data;
                aidr_pkg::REG_TARGET_MAP: target_map_reg <= cfg_data[31:0];
                aidr_pkg::REG_OUT_NORMAL: out_normal_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // per-channel evaluation
    always_comb
    begin
        lvl     = sample_reg[cmd.chan];
        old     = levels_reg[cmd.chan];
        cnt     = count_reg[cmd.chan];
        differ  = lvl ^ old;
        cnt_inc = (cnt == aidr_pkg::COUNT_MAX) ? cnt : cnt + 1'b1;
        stable  = stable_reg[8*cmd.chan +: 8];
        reach   = differ && (aidr_pkg::CMP_W'(cnt_inc) >= aidr_pkg::CMP_W'(stable));
        en      = enable_reg[cmd.chan];
        tgt     = target_map_reg[4*cmd.chan +: 4];

        if (!differ || reach)
            cnt_next = '0;
        else
            cnt_next = cnt_inc;

        levels_next            = levels_reg;
        levels_next[cmd.chan]  = reach ? lvl : old;

        res_now.in_channel = 3'(cmd.chan);
        res_now.new_level  = lvl;
        res_now.abnormal   = lvl ^ in_normal_reg[cmd.chan];
        if (tgt >= aidr_pkg::TARGET_W'(aidr_pkg::OUT_CHANNELS))
        begin
            res_now.out_channel = aidr_pkg::NO_OUTPUT;
            res_now.out_drive   = 1'b0;
        end
        else
        begin
            res_now.out_channel = tgt;
            res_now.out_drive   = out_normal_reg[tgt[aidr_pkg::OUT_IDX_W-1:0]]
                                  ^ res_now.abnormal;
        end
    end

    assign sts.primed     = primed_reg;
    assign sts.hit        = reach && en;
    assign sts.pend_valid = pend_valid_reg;
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign push_mid = cmd.step && sts.hit && pend_valid_reg;

    // debounce state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg <= 1'b0;
            levels_reg <= '0;
            for (int i = 0; i < NI; i++)
                count_reg[i] <= '0;
        end
        else if (cmd.prime)
        begin
            primed_reg <= 1'b1;
            levels_reg <= alarm_sample[NI-1:0];
            for (int i = 0; i < NI; i++)
                count_reg[i] <= '0;
        end
        else if (cmd.step)
        begin
            levels_reg          <= levels_next;
            count_reg[cmd.chan] <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            sample_reg <= alarm_sample[NI-1:0];
    end

    // pending result and output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.step && sts.hit)
                pend_valid_reg <= 1'b1;
            else if (cmd.flush)
                pend_valid_reg <= 1'b0;

            if (push_mid || cmd.flush)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step && sts.hit)
            pend_reg <= res_now;
        if (push_mid || cmd.flush)
        begin
            out_reg      <= pend_reg;
            out_last_reg <= cmd.flush;
        end
    end

    assign out_valid   = out_valid_reg;
    assign in_channel  = out_reg.in_channel;
    assign new_level   = out_reg.new_level;
    assign abnormal    = out_reg.abnormal;
    assign out_channel = out_reg.out_channel;
    assign out_drive   = out_reg.out_drive;
    assign last_event  = out_last_reg;

endmodule

>>> rtl/alarm_input_debounce_relay.sv
`timescale 1ns / 1ps
// Alarm input debounce and relay.
// Input channel (in_valid/in_ready, alarm_sample): one word per poll tick,
// bit i the sampled level of alarm input i.
// Output channel (out_valid/out_ready): one word per accepted level change
// on an enabled input, in ascending channel order; last_event marks the
// final word of a tick. A tick with no change gives no word.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready,
// one register per write; unknown indexes are dropped. Write only when idle.
// Sequencing: the first tick after reset only loads the accepted levels.
// Later ticks are scanned one input per cycle by the sequencer while the
// scan does not stall, and closed by a flush; a new tick is not taken
// until the flush is done.
// A result is held one slot behind the scan so the last word can be marked;
// it reaches the output register at the next hit or at the flush.
// Stall: the scan halts on a hit only when both the pending slot and the
// output register are full, and the flush waits for the output register.
// Reset: config returns to defaults, levels and counts clear, output empty.

module alarm_input_debounce_relay (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  alarm_sample,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  in_channel,
    output logic        new_level,
    output logic        abnormal,
    output logic [3:0]  out_channel,
    output logic        out_drive,
    output logic        last_event
);

    aidr_pkg::aidr_cmd_t cmd;
    aidr_pkg::aidr_sts_t sts;

    // config writes are always accepted
    assign cfg_ready = 1'b1;

    aidr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    aidr_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .alarm_sample (alarm_sample),
        .cmd          (cmd),
        .sts          (sts),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .in_channel   (in_channel),
        .new_level    (new_level),
        .abnormal     (abnormal),
        .out_channel  (out_channel),
        .out_drive    (out_drive),
        .last_event   (last_event)
    );

endmodule

>>> rtl/aidr_checker.sv
`timescale 1ns / 1ps

module aidr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] in_channel,
    input logic       new_level,
    input logic       abnormal,
    input logic [3:0] out_channel,
    input logic       out_drive,
    input logic       last_event
);

    // stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(in_channel)
            && $stable(new_level) && $stable(abnormal) && $stable(out_channel)
            && $stable(out_drive) && $stable(last_event))
        else $error("output word changed while stalled");

    // no mapped output means no drive
    a_no_drive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_channel[3] == 1'b1) |-> out_channel == 4'd8 && !out_drive)
        else $error("bad output mapping in word");

    // words within a tick rise in channel order
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_event |=>
            !out_valid || (in_channel > $past(in_channel)))
        else $error("words of a tick out of channel order");

endmodule

bind alarm_input_debounce_relay aidr_checker u_aidr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .in_channel  (in_channel),
    .new_level   (new_level),
    .abnormal    (abnormal),
    .out_channel (out_channel),
    .out_drive   (out_drive),
    .last_event  (last_event)
);
